// ===== hw/rtl/mssd_pkg.sv =====
// ----------------------------------------------------------------------------
// mssd_pkg
// shared widths, op codes, config indexes and the hex glyph table for the
// multiplexed seven-segment driver
// ----------------------------------------------------------------------------
package mssd_pkg;

    localparam int DIGIT_COUNT_DEF = 14;

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 4;
    localparam int VAL_W   = 32;
    localparam int SEG_W   = 8;
    localparam int COM_W   = 14;
    localparam int POS_W   = 4;
    localparam int NIB_W   = 4;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W   = BCD_DIGITS * NIB_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
    localparam logic [OP_W-1:0] OP_RAW   = 3'd1;
    localparam logic [OP_W-1:0] OP_POINT = 3'd2;
    localparam logic [OP_W-1:0] OP_HEX   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_POL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COM_POL = 1'b1;

    localparam logic [SEG_W-1:0] HEX_CLAMP = 8'hFF;

    // one write into the digit store per cycle, or a full clear
    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [SEG_W-1:0]  data;
        logic              clr;
    } store_cmd_t;

    function automatic logic [SEG_W-1:0] glyph(input logic [NIB_W-1:0] n);
        logic [SEG_W-1:0] g;
        begin
            case (n)
                4'h0: g = 8'b00111111;
                4'h1: g = 8'b00000110;
                4'h2: g = 8'b01011011;
                4'h3: g = 8'b01001111;
                4'h4: g = 8'b01100110;
                4'h5: g = 8'b01101101;
                4'h6: g = 8'b01111101;
                4'h7: g = 8'b00000111;
                4'h8: g = 8'b01111111;
                4'h9: g = 8'b01101111;
                4'hA: g = 8'b01110111;
                4'hB: g = 8'b01111100;
                4'hC: g = 8'b00111101;
                4'hD: g = 8'b01011110;
                4'hE: g = 8'b01111001;
                4'hF: g = 8'b01110001;
                default: g = '0;
            endcase
            return g;
        end
    endfunction

endpackage

// ===== hw/rtl/multiplexed_seven_segment_driver_top.sv =====
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_driver_top
// multiplexed seven-segment display controller: digit store, scan tick,
// raw/point writes, hex and bit-serial decimal display, clear
// ----------------------------------------------------------------------------
// show hex writes two store digits; show decimal runs the bit-serial bcd
//   converter and then makes 10 digit writes to the store
// throughput: one item at a time; the next item is taken once the result
//   moves to the output register, even while that result is still stalled
// reset: store blank, scan position zero, segments and commons off,
//   both polarity registers zero, no result pending
module multiplexed_seven_segment_driver_top #(
    parameter int DIGIT_COUNT = mssd_pkg::DIGIT_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [mssd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mssd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input item channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mssd_pkg::OP_W-1:0]         op,
    input  logic [mssd_pkg::ADDR_W-1:0]       digit_index,
    input  logic [mssd_pkg::VAL_W-1:0]        value,
    input  logic [mssd_pkg::SEG_W-1:0]        segment_pattern,
    input  logic                              point_on,
    // result item channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mssd_pkg::SEG_W-1:0]        segment_lines,
    output logic [mssd_pkg::COM_W-1:0]        common_lines,
    output logic [mssd_pkg::POS_W-1:0]        next_position
);

    localparam logic [mssd_pkg::POS_W-1:0]  LAST_POS  = mssd_pkg::POS_W'(DIGIT_COUNT - 1);
    localparam logic [mssd_pkg::ADDR_W-1:0] DIG_COUNT = mssd_pkg::ADDR_W'(DIGIT_COUNT - 1);
    localparam int WCNT_W = $clog2(mssd_pkg::BCD_DIGITS);
    localparam logic [WCNT_W-1:0] WCNT_LAST = WCNT_W'(mssd_pkg::BCD_DIGITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EXEC  = 6'b000010,
        ST_HEXLO = 6'b000100,
        ST_CONV  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // latched item fields
    logic [mssd_pkg::OP_W-1:0]   op_reg;
    logic [mssd_pkg::ADDR_W-1:0] idx_reg;
    logic [mssd_pkg::SEG_W-1:0]  pattern_reg;
    logic                        point_reg;
    logic [mssd_pkg::SEG_W-1:0]  hex_val_reg;
    logic [mssd_pkg::VAL_W-1:0]  value_reg;

    // display state
    logic [mssd_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [mssd_pkg::SEG_W-1:0]  seg_drive_reg, seg_drive_next;
    logic [mssd_pkg::COM_W-1:0]  com_drive_reg, com_drive_next;
    logic                        seg_al_reg, com_al_reg;

    // decimal write sequencer
    logic [WCNT_W-1:0]           wcnt_reg, wcnt_next;

    // result register
    logic                        out_valid_reg, out_valid_next;
    logic [mssd_pkg::SEG_W-1:0]  seg_out_reg;
    logic [mssd_pkg::COM_W-1:0]  com_out_reg;
    logic [mssd_pkg::POS_W-1:0]  pos_out_reg;

    mssd_pkg::store_cmd_t        store_cmd;
    logic [mssd_pkg::ADDR_W-1:0] rd_addr;
    logic [mssd_pkg::SEG_W-1:0]  rd_data;

    logic                        accept;
    logic                        load_out;
    logic                        bcd_start;
    logic                        bcd_shift;
    logic                        bcd_done;
    logic [mssd_pkg::NIB_W-1:0]  bcd_digit;
    logic                        idx_ok;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign idx_ok   = (idx_reg <= DIG_COUNT);

    // set point reads the addressed digit, a tick reads the scan digit
    assign rd_addr = (op_reg == mssd_pkg::OP_POINT) ? idx_reg : pos_reg;

    mssd_store #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (store_cmd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mssd_bcd u_bcd (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (bcd_start),
        .value     (value_reg),
        .shift_out (bcd_shift),
        .done      (bcd_done),
        .digit     (bcd_digit)
    );

    // sequencer: one item from accept through its store writes to the result
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        seg_drive_next = seg_drive_reg;
        com_drive_next = com_drive_reg;
        wcnt_next      = wcnt_reg;
        store_cmd      = '0;
        bcd_start      = 1'b0;
        bcd_shift      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (op_reg)
                    mssd_pkg::OP_TICK:
                    begin
                        seg_drive_next = rd_data;
                        // positions past the common field width drop out
                        com_drive_next = {{(mssd_pkg::COM_W-1){1'b0}}, 1'b1} << pos_reg;
                        pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
                    end
                    mssd_pkg::OP_RAW:
                    begin
                        store_cmd.wr   = idx_ok;
                        store_cmd.addr = idx_reg;
                        store_cmd.data = pattern_reg;
                    end
                    mssd_pkg::OP_POINT:
                    begin
                        store_cmd.wr   = idx_ok;
                        store_cmd.addr = idx_reg;
                        store_cmd.data = {point_reg, rd_data[mssd_pkg::SEG_W-2:0]};
                    end
                    mssd_pkg::OP_HEX:
                    begin
                        // high nibble to position one, low nibble next cycle
                        store_cmd.wr   = 1'b1;
                        store_cmd.addr = mssd_pkg::ADDR_W'(1);
                        store_cmd.data = mssd_pkg::glyph(hex_val_reg[7:4]);
                        state_next     = ST_HEXLO;
                    end
                    mssd_pkg::OP_DEC:
                    begin
                        bcd_start  = 1'b1;
                        state_next = ST_CONV;
                    end
                    mssd_pkg::OP_CLEAR:
                    begin
                        store_cmd.clr  = 1'b1;
                        com_drive_next = '0;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_HEXLO:
            begin
                store_cmd.wr   = 1'b1;
                store_cmd.addr = '0;
                store_cmd.data = mssd_pkg::glyph(hex_val_reg[3:0]);
                state_next     = ST_DONE;
            end
            ST_CONV:
            begin
                wcnt_next = '0;
                if (bcd_done)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // most significant digit first, to position zero
                store_cmd.wr   = 1'b1;
                store_cmd.addr = mssd_pkg::ADDR_W'(wcnt_reg);
                store_cmd.data = mssd_pkg::glyph(bcd_digit);
                bcd_shift      = 1'b1;
                wcnt_next      = wcnt_reg + 1'b1;
                if (wcnt_reg == WCNT_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            seg_drive_reg <= '0;
            com_drive_reg <= '0;
            seg_al_reg    <= 1'b0;
            com_al_reg    <= 1'b0;
            wcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            seg_drive_reg <= seg_drive_next;
            com_drive_reg <= com_drive_next;
            wcnt_reg      <= wcnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    mssd_pkg::CFG_SEG_POL: seg_al_reg <= cfg_data[0];
                    mssd_pkg::CFG_COM_POL: com_al_reg <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // item payload and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            idx_reg     <= digit_index;
            pattern_reg <= segment_pattern;
            point_reg   <= point_on;
            value_reg   <= value;
            // clamp to one byte for the two hex digits
            hex_val_reg <= (|value[mssd_pkg::VAL_W-1:mssd_pkg::SEG_W])
                           ? mssd_pkg::HEX_CLAMP : value[mssd_pkg::SEG_W-1:0];
        end
        if (load_out)
        begin
            seg_out_reg <= seg_drive_reg ^ {mssd_pkg::SEG_W{seg_al_reg}};
            com_out_reg <= com_drive_reg ^ {mssd_pkg::COM_W{com_al_reg}};
            pos_out_reg <= pos_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign segment_lines = seg_out_reg;
    assign common_lines  = com_out_reg;
    assign next_position = pos_out_reg;

    // a new result only ever comes out of the done state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result register loaded outside the done state");

    // scan position stays inside the store
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("scan position beyond last digit");

    // at most one common enabled at a time
    a_common_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(com_drive_reg))
        else $error("more than one common driven");

    // digit writes start only once the converter has finished
    a_write_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> bcd_done)
        else $error("decimal digit written before conversion done");

endmodule

// ===== hw/rtl/mssd_bcd.sv =====
// ----------------------------------------------------------------------------
// mssd_bcd
// bit-serial binary to bcd converter (shift and add three), one input bit
// per cycle, digits then shifted out most significant first
// ----------------------------------------------------------------------------
module mssd_bcd (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mssd_pkg::VAL_W-1:0]    value,
    input  logic                          shift_out,
    output logic                          done,
    output logic [mssd_pkg::NIB_W-1:0]    digit
);

    localparam int CNT_W = $clog2(mssd_pkg::VAL_W + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(mssd_pkg::VAL_W);

    logic [mssd_pkg::VAL_W-1:0] bin_reg, bin_next;
    logic [mssd_pkg::BCD_W-1:0] bcd_reg, bcd_next;
    logic [mssd_pkg::BCD_W-1:0] bcd_adj;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < mssd_pkg::BCD_DIGITS; i++)
        begin
            if (bcd_reg[i*mssd_pkg::NIB_W +: mssd_pkg::NIB_W] >= 4'd5)
                bcd_adj[i*mssd_pkg::NIB_W +: mssd_pkg::NIB_W] =
                    bcd_reg[i*mssd_pkg::NIB_W +: mssd_pkg::NIB_W] + 4'd3;
            else
                bcd_adj[i*mssd_pkg::NIB_W +: mssd_pkg::NIB_W] =
                    bcd_reg[i*mssd_pkg::NIB_W +: mssd_pkg::NIB_W];
        end
    end

    assign done  = (cnt_reg == CNT_END);
    assign digit = bcd_reg[mssd_pkg::BCD_W-1 -: mssd_pkg::NIB_W];

    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            bin_next = value;
            bcd_next = '0;
            cnt_next = '0;
        end
        else if (!done)
        begin
            bcd_next = {bcd_adj[mssd_pkg::BCD_W-2:0], bin_reg[mssd_pkg::VAL_W-1]};
            bin_next = {bin_reg[mssd_pkg::VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        else if (shift_out)
        begin
            bcd_next = {bcd_reg[mssd_pkg::BCD_W-mssd_pkg::NIB_W-1:0],
                        {mssd_pkg::NIB_W{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= CNT_END;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

// ===== hw/rtl/mssd_store.sv =====
// ----------------------------------------------------------------------------
// mssd_store
// digit store: one segment byte per position, one write per cycle, full
// clear, one read port
// ----------------------------------------------------------------------------
module mssd_store #(
    parameter int DIGIT_COUNT = mssd_pkg::DIGIT_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mssd_pkg::store_cmd_t          cmd,
    input  logic [mssd_pkg::ADDR_W-1:0]   rd_addr,
    output logic [mssd_pkg::SEG_W-1:0]    rd_data
);

    logic [mssd_pkg::SEG_W-1:0] store_reg [DIGIT_COUNT];

    // out of range addresses match no entry, so writes there are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                if (cmd.clr)
                    store_reg[i] <= '0;
                else if (cmd.wr && (cmd.addr == mssd_pkg::ADDR_W'(i)))
                    store_reg[i] <= cmd.data;
            end
        end
    end

    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            if (rd_addr == mssd_pkg::ADDR_W'(i))
                rd_data = store_reg[i];
        end
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the multiplexed seven-segment driver: a local
// predictor of the digit store, scan position and pin polarity forecasts the
// pin levels for every item, and each result is matched against the oldest
// forecast while both handshake sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int DIGITS        = mssd_pkg::DIGIT_COUNT_DEF;
    localparam int STORE_SLOTS   = 16;
    // longest quiet stretch of a correct run spans a sender gap, a show
    // decimal item and a receiver stall
    localparam int STALL_LIMIT   = 2000;
    // show decimal is the slowest op
    localparam int SETTLE_CYCLES = 50;
    localparam int POINT_BIT     = mssd_pkg::SEG_W - 1;

    // op codes the block treats as no-ops
    localparam logic [mssd_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [mssd_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    // segment glyphs for 0..f, entry n at bits [8n+7:8n]
    localparam logic [16*mssd_pkg::SEG_W-1:0] GLYPH_ROM = {
        8'h71, 8'h79, 8'h5E, 8'h3D, 8'h7C, 8'h77, 8'h6F, 8'h7F,
        8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    // pin levels reported by one result item
    typedef struct packed {
        logic [mssd_pkg::SEG_W-1:0] seg;
        logic [mssd_pkg::COM_W-1:0] com;
        logic [mssd_pkg::POS_W-1:0] pos;
    } pins_t;

    // ------------------------------------------------------------------
    // dut signals, every input known from time zero
    // ------------------------------------------------------------------
    logic                            clk;
    logic                            rst_n           = 1'b0;
    logic                            cfg_we          = 1'b0;
    logic [mssd_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [mssd_pkg::CFG_DATA_W-1:0] cfg_data        = '0;
    logic                            in_valid        = 1'b0;
    logic                            in_stall;
    logic [mssd_pkg::OP_W-1:0]       op              = mssd_pkg::OP_TICK;
    logic [mssd_pkg::ADDR_W-1:0]     digit_index     = '0;
    logic [mssd_pkg::VAL_W-1:0]      value           = '0;
    logic [mssd_pkg::SEG_W-1:0]      segment_pattern = '0;
    logic                            point_on        = 1'b0;
    logic                            out_valid;
    logic                            out_stall       = 1'b0;
    logic [mssd_pkg::SEG_W-1:0]      segment_lines;
    logic [mssd_pkg::COM_W-1:0]      common_lines;
    logic [mssd_pkg::POS_W-1:0]      next_position;

    multiplexed_seven_segment_driver_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .digit_index     (digit_index),
        .value           (value),
        .segment_pattern (segment_pattern),
        .point_on        (point_on),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .segment_lines   (segment_lines),
        .common_lines    (common_lines),
        .next_position   (next_position)
    );

    // ------------------------------------------------------------------
    // predictor state: digit store, scan position, drives, polarity
    // ------------------------------------------------------------------
    logic [mssd_pkg::SEG_W-1:0] model_store [STORE_SLOTS];
    logic [mssd_pkg::POS_W-1:0] model_pos;
    logic [mssd_pkg::SEG_W-1:0] model_seg;
    logic [mssd_pkg::COM_W-1:0] model_com;
    logic                       model_seg_inv;
    logic                       model_com_inv;

    pins_t pending_pins [$];     // forecasts waiting for their result item
    int    mismatch_count = 0;
    int    out_wait       = 0;   // receiver stall cycles still to serve
    bit    no_idle        = 1'b0; // when set neither side idles

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // blank glyph for anything that is not a single hex digit
    function automatic logic [mssd_pkg::SEG_W-1:0] hex_seg(
        input logic [mssd_pkg::VAL_W-1:0] n);
        if (n > 15)
            return '0;
        return GLYPH_ROM[n[3:0] * mssd_pkg::SEG_W +: mssd_pkg::SEG_W];
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < STORE_SLOTS; i++)
            model_store[i] = '0;
        model_pos     = '0;
        model_seg     = '0;
        model_com     = '0;
        model_seg_inv = 1'b0;
        model_com_inv = 1'b0;
    endfunction

    // applies one item to the predictor and returns the pin levels it reports
    function automatic pins_t predict_pins(input logic [mssd_pkg::OP_W-1:0] code,
                                           input logic [mssd_pkg::ADDR_W-1:0] idx,
                                           input logic [mssd_pkg::VAL_W-1:0] num,
                                           input logic [mssd_pkg::SEG_W-1:0] pat,
                                           input logic pt);
        pins_t                      r;
        logic [mssd_pkg::VAL_W-1:0] rem;
        logic [mssd_pkg::VAL_W-1:0] decade;
        logic [mssd_pkg::VAL_W-1:0] clamped;
        case (code)
            mssd_pkg::OP_TICK:
            begin
                if (model_pos >= DIGITS)
                    model_pos = '0;
                model_seg = model_store[model_pos];
                model_com = {{(mssd_pkg::COM_W-1){1'b0}}, 1'b1} << model_pos;
                // wrap after the last digit
                if (model_pos == DIGITS - 1)
                    model_pos = '0;
                else
                    model_pos = model_pos + 1'b1;
            end
            mssd_pkg::OP_RAW:
            begin
                if (idx < DIGITS)
                    model_store[idx] = pat;
            end
            mssd_pkg::OP_POINT:
            begin
                if (idx < DIGITS)
                    model_store[idx][POINT_BIT] = pt;
            end
            mssd_pkg::OP_HEX:
            begin
                // anything above one byte shows as ff
                clamped = (num > mssd_pkg::VAL_W'(mssd_pkg::HEX_CLAMP))
                          ? mssd_pkg::VAL_W'(mssd_pkg::HEX_CLAMP) : num;
                model_store[1] = hex_seg({28'd0, clamped[7:4]});
                model_store[0] = hex_seg({28'd0, clamped[3:0]});
            end
            mssd_pkg::OP_DEC:
            begin
                // ten digits, most significant at position 0, leading zeros kept
                rem    = num;
                decade = 32'd1000000000;
                for (int i = 0; i < mssd_pkg::BCD_DIGITS; i++)
                begin
                    model_store[i] = hex_seg(rem / decade);
                    rem    = rem % decade;
                    decade = decade / 10;
                end
            end
            mssd_pkg::OP_CLEAR:
            begin
                // commons off and store blank, segment drive and scan kept
                model_com = '0;
                for (int i = 0; i < STORE_SLOTS; i++)
                    model_store[i] = '0;
            end
            default:
            begin
            end
        endcase
        r.seg = model_seg ^ {mssd_pkg::SEG_W{model_seg_inv}};
        r.com = model_com ^ {mssd_pkg::COM_W{model_com_inv}};
        r.pos = model_pos;
        return r;
    endfunction

    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    // numbers biased toward the clamp edge, decade edges and the extremes
    function automatic logic [mssd_pkg::VAL_W-1:0] draw_value();
        case ($urandom_range(0, 6))
            0: return $urandom_range(0, 15);
            1: return $urandom_range(0, 255);
            2: return $urandom_range(250, 300);
            3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            4: return $urandom_range(999_999_990, 1_000_000_010);
            5: return $urandom_range(0, 99_999);
            default: return $urandom();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender: one item, random gap first, payload held while stalled
    // ------------------------------------------------------------------
    task automatic send_item(input logic [mssd_pkg::OP_W-1:0] code,
                             input logic [mssd_pkg::ADDR_W-1:0] idx,
                             input logic [mssd_pkg::VAL_W-1:0] num,
                             input logic [mssd_pkg::SEG_W-1:0] pat,
                             input logic pt);
        int gap;
        gap = draw_wait();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op              <= code;
        digit_index     <= idx;
        value           <= num;
        segment_pattern <= pat;
        point_on        <= pt;
        in_valid        <= 1'b1;
        // accepted at the first rising edge with stall low
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        pending_pins.push_back(predict_pins(code, idx, num, pat, pt));
    endtask

    task automatic send_random_item();
        logic [mssd_pkg::OP_W-1:0]   code;
        logic [mssd_pkg::ADDR_W-1:0] idx;
        int                          pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            code = mssd_pkg::OP_TICK;
        else if (pick < 55)
            code = mssd_pkg::OP_RAW;
        else if (pick < 67)
            code = mssd_pkg::OP_POINT;
        else if (pick < 78)
            code = mssd_pkg::OP_HEX;
        else if (pick < 87)
            code = mssd_pkg::OP_DEC;
        else if (pick < 93)
            code = mssd_pkg::OP_CLEAR;
        else if (pick < 97)
            code = OP_SPARE_A;
        else
            code = OP_SPARE_B;
        // mostly in-range positions, some beyond the store
        if ($urandom_range(0, 9) < 8)
            idx = mssd_pkg::ADDR_W'($urandom_range(0, DIGITS - 1));
        else
            idx = mssd_pkg::ADDR_W'($urandom_range(0, 15));
        send_item(code, idx, draw_value(), mssd_pkg::SEG_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // drop valid and hold off until every forecast has been matched
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
    endtask

    // register writes only while the block has nothing in flight
    task automatic write_polarity(input logic [mssd_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [mssd_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        if (idx == mssd_pkg::CFG_SEG_POL)
            model_seg_inv = data[0];
        else
            model_com_inv = data[0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_polarity(input logic seg_inv, input logic com_inv);
        write_polarity(mssd_pkg::CFG_SEG_POL, seg_inv);
        write_polarity(mssd_pkg::CFG_COM_POL, com_inv);
    endtask

    // ------------------------------------------------------------------
    // receiver: stalls for a random count after each accepted result
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (out_wait > 0)
        begin
            out_stall <= 1'b1;
            out_wait  <= out_wait - 1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // compare each accepted result with the oldest forecast
    always @(posedge clk)
    begin : result_check
        pins_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            out_wait <= draw_wait();
            if (pending_pins.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual seg %h com %h pos %h",
                         $time, segment_lines, common_lines, next_position);
                mismatch_count++;
            end
            else
            begin
                want = pending_pins.pop_front();
                if (segment_lines !== want.seg)
                begin
                    $display("%0t: segment_lines expected %h actual %h",
                             $time, want.seg, segment_lines);
                    mismatch_count++;
                end
                if (common_lines !== want.com)
                begin
                    $display("%0t: common_lines expected %h actual %h",
                             $time, want.com, common_lines);
                    mismatch_count++;
                end
                if (next_position !== want.pos)
                begin
                    $display("%0t: next_position expected %0d actual %0d",
                             $time, want.pos, next_position);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: ends the run once nothing has been accepted for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every op at least once, store edges, out-of-store indexes, hex clamp,
    // decimal extremes, spare codes and clear
    task automatic test_directed_ops();
        send_item(mssd_pkg::OP_TICK, 4'd0, '0, '0, 1'b0);             // blank digit 0
        send_item(mssd_pkg::OP_RAW, 4'd0, '0, 8'hFF, 1'b0);
        send_item(mssd_pkg::OP_RAW, 4'd13, '0, 8'hA5, 1'b1);          // last digit
        send_item(mssd_pkg::OP_RAW, 4'd14, '0, 8'h5A, 1'b0);          // beyond store
        send_item(mssd_pkg::OP_RAW, 4'd15, '0, 8'hC3, 1'b1);          // beyond store
        send_item(mssd_pkg::OP_TICK, 4'd0, '0, '0, 1'b0);
        send_item(mssd_pkg::OP_POINT, 4'd13, '0, '0, 1'b0);           // last digit point
        send_item(mssd_pkg::OP_POINT, 4'd0, '0, '0, 1'b0);
        send_item(mssd_pkg::OP_POINT, 4'd15, '0, '0, 1'b1);           // beyond store
        send_item(mssd_pkg::OP_POINT, 4'd5, '0, '0, 1'b1);
        send_item(mssd_pkg::OP_HEX, 4'd0, 32'hFFFF_FFFF, '0, 1'b0);   // clamps to ff
        send_item(mssd_pkg::OP_HEX, 4'd0, 32'h0000_0100, '0, 1'b0);   // just above clamp
        send_item(mssd_pkg::OP_HEX, 4'd0, 32'h0000_000A, '0, 1'b0);
        send_item(mssd_pkg::OP_DEC, 4'd0, 32'hFFFF_FFFF, '0, 1'b0);   // largest decimal
        send_item(mssd_pkg::OP_DEC, 4'd0, 32'd0, '0, 1'b0);           // all leading zeros
        send_item(OP_SPARE_A, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_item(OP_SPARE_B, 4'hF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_item(mssd_pkg::OP_TICK, 4'd0, '0, '0, 1'b0);
        send_item(mssd_pkg::OP_CLEAR, 4'd0, '0, '0, 1'b0);            // segments kept
        send_item(mssd_pkg::OP_TICK, 4'd0, '0, '0, 1'b0);
    endtask

    // each polarity combination with a short random burst
    task automatic test_polarity_settings();
        for (int s = 0; s < 4; s++)
        begin
            set_polarity(s[0], s[1]);
            repeat (40) send_random_item();
        end
    endtask

    // back-to-back burst, drained until all results are in, then a burst with random gaps
    task automatic test_pause_until_drained();
        no_idle = 1'b1;
        repeat (30) send_random_item();
        wait_drained();
        no_idle = 1'b0;
        repeat (30) send_random_item();
    endtask

    // phases of random items, polarity and idling changed between phases
    task automatic test_random_mix();
        for (int phase = 0; phase < 12; phase++)
        begin
            set_polarity(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
            begin
                send_random_item();
                // now and then let the pipe empty completely
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers written once at their reset values
        set_polarity(1'b0, 1'b0);

        test_directed_ops();
        test_polarity_settings();
        test_pause_until_drained();
        test_random_mix();

        // drain, then give any stray result time to show up
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pins.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_pins.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
